FILE: hw/rtl/ptwe_pkg.sv
// Shared types, defaults and controller/datapath codes of the page table walker.
package ptwe_pkg;

    localparam int PTWE_OFFSET_BITS = 4;
    localparam int PTWE_LEVELS      = 2;
    localparam int PTWE_VADDR_BITS  = 12;
    localparam int PTWE_FRAME_COUNT = 16;
    localparam int PTWE_WORD_BITS   = 32;

    localparam int VA_W      = 12;
    localparam int WDATA_W   = 32;
    localparam int RDATA_W   = 32;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 32;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK_CHK,
        ST_SC_RD,
        ST_SC_CHK,
        ST_SC_ADV,
        ST_UNLINK,
        ST_TAKE,
        ST_EV_RD,
        ST_EV_WR,
        ST_EV_FIN,
        ST_LINK,
        ST_REST,
        ST_RS_RD,
        ST_RS_WR,
        ST_RS_FIN,
        ST_ACC,
        ST_RESP,
        ST_FAIL
    } state_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_LOAD,
        OP_WALK_RD,
        OP_WALK_ADV,
        OP_SCAN_INIT,
        OP_SCAN_RD,
        OP_SCAN_CHK,
        OP_SCAN_ADV,
        OP_UNLINK,
        OP_GROW,
        OP_EVICT_RD,
        OP_EVICT_WR,
        OP_EVICT_FIN,
        OP_LINK,
        OP_REST_RD,
        OP_REST_WR,
        OP_REST_FIN,
        OP_ACC,
        OP_RESULT_OK,
        OP_RESULT_FAIL
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
        logic   in_ready;
    } dp_cmd_t;

    typedef struct packed {
        logic in_oor;
        logic ent_nz;
        logic walk_last;
        logic leaf;
        logic idx_last;
        logic tbl_empty;
        logic d_zero;
        logic can_grow;
        logic victim;
        logic k_last;
        logic rest_need;
        logic out_busy;
    } dp_status_t;

endpackage

FILE: hw/rtl/page_table_walk_with_eviction_unit.sv
// Top level of the demand-paged page table walker with cyclic-distance eviction.
//
//  channel | direction | tdata (low bit up)                      | tuser
//  s_      | in        | virtual_address[11:0], write_data[43:12] | func (0 read, 1 write)
//  m_      | out       | read_data[31:0]                          | ok
//
// A hit makes one registered physical-store read per level.
// A page fault adds a depth-first scan over the table entries, plus a copy of
// each page word to swap for an eviction and back from swap for a restore.
// One transaction is in work at a time; the next is taken once its result is
// in the output register, which holds while m_tready is low.
// Reset is synchronous on aresetn; the physical store and swap flags read as
// zero right after reset, with no clearing pass.
module page_table_walk_with_eviction_unit #(
    parameter int OFFSET_BITS = ptwe_pkg::PTWE_OFFSET_BITS,
    parameter int LEVELS      = ptwe_pkg::PTWE_LEVELS,
    parameter int VADDR_BITS  = ptwe_pkg::PTWE_VADDR_BITS,
    parameter int FRAME_COUNT = ptwe_pkg::PTWE_FRAME_COUNT,
    parameter int WORD_BITS   = ptwe_pkg::PTWE_WORD_BITS
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [ptwe_pkg::S_TDATA_W-1:0] s_tdata,  // virtual_address, write_data, pad
    input  logic                           s_tuser,  // func
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [ptwe_pkg::M_TDATA_W-1:0] m_tdata,  // read_data
    output logic                           m_tuser   // ok
);
    import ptwe_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    ptwe_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .status   (status),
        .cmd      (cmd)
    );

    ptwe_dp #(
        .OFFSET_BITS (OFFSET_BITS),
        .LEVELS      (LEVELS),
        .VADDR_BITS  (VADDR_BITS),
        .FRAME_COUNT (FRAME_COUNT),
        .WORD_BITS   (WORD_BITS)
    ) u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    assign s_tready = cmd.in_ready;

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction taken while one is in work");

    a_idle_no_work: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready |-> (cmd.op == OP_NONE || cmd.op == OP_LOAD))
        else $error("datapath busy while input is ready");

    a_refused_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("refused access carries nonzero data");

endmodule

FILE: hw/rtl/ptwe_dp.sv
// Datapath: physical store, swap store, walk and scan registers, result register.
module ptwe_dp #(
    parameter int OFFSET_BITS = 4,
    parameter int LEVELS      = 2,
    parameter int VADDR_BITS  = 12,
    parameter int FRAME_COUNT = 16,
    parameter int WORD_BITS   = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ptwe_pkg::dp_cmd_t                  cmd,
    output ptwe_pkg::dp_status_t               status,
    input  logic [ptwe_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic                               s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [ptwe_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tuser
);
    import ptwe_pkg::*;

    localparam int PW         = 1 << OFFSET_BITS;
    localparam int FB         = $clog2(FRAME_COUNT);
    localparam int PA_W       = FB + OFFSET_BITS;
    localparam int PHYS_WORDS = FRAME_COUNT * PW;
    localparam int PAGE_BITS  = (VADDR_BITS > OFFSET_BITS) ? (VADDR_BITS - OFFSET_BITS) : 0;
    localparam int PG_W       = (PAGE_BITS > 0) ? PAGE_BITS : 1;
    localparam int PAGE_COUNT = 1 << PAGE_BITS;
    localparam int SW_AW      = PAGE_BITS + OFFSET_BITS;
    localparam int ROOT_BITS  = (VADDR_BITS % OFFSET_BITS != 0) ?
                                (VADDR_BITS % OFFSET_BITS) : OFFSET_BITS;
    localparam int LVL_W      = (LEVELS > 1) ? $clog2(LEVELS) : 1;
    localparam int I_W        = $clog2(LEVELS + 1);
    localparam int SHIFT_W    = $clog2(LEVELS * OFFSET_BITS + 1);
    localparam logic [OFFSET_BITS-1:0] ROOT_MASK = OFFSET_BITS'((1 << ROOT_BITS) - 1);
    localparam logic [PG_W:0]          NP_C      = (PG_W + 1)'(1) << PAGE_BITS;
    localparam logic [LVL_W-1:0]       LEAF_D    = LVL_W'(LEVELS - 1);
    localparam logic [I_W-1:0]         LAST_I    = I_W'(LEVELS - 1);

    // memories
    logic [WORD_BITS-1:0] phys_mem [PHYS_WORDS];
    logic [WORD_BITS-1:0] swap_mem [1 << SW_AW];
    logic [PHYS_WORDS-1:0] valid_reg;
    logic [PAGE_COUNT-1:0] saved_reg;
    logic [WORD_BITS-1:0]  phys_rd_reg;
    logic                  phys_rvld_reg;
    logic [WORD_BITS-1:0]  swap_rd_reg;

    // access registers
    logic                     func_reg;
    logic [VA_W-1:0]          va_reg;
    logic signed [WDATA_W-1:0] wd_reg;
    logic [PG_W-1:0]          page_reg;
    logic [FB-1:0]            cur_reg;
    logic [I_W-1:0]           i_reg;
    logic                     linked_reg;
    logic [OFFSET_BITS-1:0]   k_reg;
    logic [FB-1:0]            nf_reg;

    // scan registers
    logic [LVL_W-1:0]       d_reg;
    logic [FB-1:0]          frame_stk_reg  [LEVELS];
    logic [PA_W-1:0]        parent_stk_reg [LEVELS];
    logic [OFFSET_BITS-1:0] idx_stk_reg    [LEVELS];
    logic                   kids_stk_reg   [LEVELS];
    logic [PG_W-1:0]        vpage_stk_reg  [LEVELS];
    logic [FB-1:0]          max_reg;
    logic                   victim_reg;
    logic [PG_W:0]          best_dist_reg;
    logic [FB-1:0]          best_frame_reg;
    logic [PG_W-1:0]        best_page_reg;
    logic [PA_W-1:0]        best_parent_reg;

    // result register
    logic                     out_valid_reg;
    logic [RDATA_W-1:0]       out_data_reg;
    logic                     out_ok_reg;

    logic [VA_W-1:0]          va_in;
    logic [WORD_BITS-1:0]     rd_word;
    logic [WORD_BITS-1:0]     wd_ext;
    logic [OFFSET_BITS-1:0]   va_off;
    logic [SHIFT_W-1:0]       walk_shift;
    logic [OFFSET_BITS-1:0]   walk_idx;
    logic [FB-1:0]            frame_cur;
    logic [PA_W-1:0]          parent_cur;
    logic [OFFSET_BITS-1:0]   idx_cur;
    logic [PG_W-1:0]          vpage_next;
    logic [PG_W-1:0]          diff;
    logic [PG_W:0]            alt;
    logic [PG_W:0]            cyc_gap;
    logic [FB-1:0]            ent_frame;
    logic [FB:0]              grow_sum;
    logic [FB-1:0]            grow_frame;
    logic                     we;
    logic [PA_W-1:0]          waddr;
    logic [WORD_BITS-1:0]     wdata;
    logic [PA_W-1:0]          raddr;

    assign va_in      = s_tdata[VA_W-1:0];
    assign rd_word    = phys_rvld_reg ? phys_rd_reg : '0;
    assign wd_ext     = WORD_BITS'(wd_reg);
    assign va_off     = OFFSET_BITS'(va_reg);
    assign frame_cur  = frame_stk_reg[d_reg];
    assign parent_cur = parent_stk_reg[d_reg];
    assign idx_cur    = idx_stk_reg[d_reg];
    assign ent_frame  = FB'(rd_word);
    assign grow_sum   = {1'b0, max_reg} + (FB + 1)'(1);
    assign grow_frame = FB'(grow_sum);

    always_comb begin
        walk_shift = SHIFT_W'((LEVELS - int'(i_reg)) * OFFSET_BITS);
        walk_idx   = OFFSET_BITS'(va_reg >> walk_shift);
        if (i_reg == '0) begin
            walk_idx = walk_idx & ROOT_MASK;
        end
    end

    // cyclic distance of the leaf under the scan cursor to the requested page
    always_comb begin
        vpage_next = (PAGE_BITS == 0) ? '0 : PG_W'({vpage_stk_reg[d_reg], idx_cur});
        diff = (vpage_next > page_reg) ? (vpage_next - page_reg) : (page_reg - vpage_next);
        alt  = NP_C - {1'b0, diff};
        cyc_gap = (alt < {1'b0, diff}) ? alt : {1'b0, diff};
    end

    always_comb begin
        status.in_oor    = (va_in >> VADDR_BITS) != '0;
        status.ent_nz    = rd_word != '0;
        status.walk_last = i_reg == LAST_I;
        status.leaf      = d_reg == LEAF_D;
        status.idx_last  = idx_cur == '1;
        status.tbl_empty = !kids_stk_reg[d_reg] && (frame_cur != cur_reg);
        status.d_zero    = d_reg == '0;
        status.can_grow  = grow_sum < (FB + 1)'(FRAME_COUNT);
        status.victim    = victim_reg;
        status.k_last    = k_reg == '1;
        status.rest_need = linked_reg && saved_reg[page_reg];
        status.out_busy  = out_valid_reg && !m_tready;
    end

    always_comb begin
        we    = 1'b0;
        waddr = {cur_reg, va_off};
        wdata = wd_ext;
        raddr = {cur_reg, va_off};
        unique case (cmd.op)
            OP_WALK_RD:   raddr = {cur_reg, walk_idx};
            OP_SCAN_RD:   raddr = {frame_cur, idx_cur};
            OP_EVICT_RD:  raddr = {best_frame_reg, k_reg};
            OP_UNLINK: begin
                we    = 1'b1;
                waddr = parent_cur;
                wdata = '0;
            end
            OP_EVICT_FIN: begin
                we    = 1'b1;
                waddr = best_parent_reg;
                wdata = '0;
            end
            OP_LINK: begin
                we    = 1'b1;
                waddr = {cur_reg, walk_idx};
                wdata = WORD_BITS'(nf_reg);
            end
            OP_REST_WR: begin
                we    = 1'b1;
                waddr = {cur_reg, k_reg};
                wdata = swap_rd_reg;
            end
            OP_ACC:       we = func_reg;
            default:      we = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            phys_mem[waddr] <= wdata;
        end
        phys_rd_reg   <= phys_mem[raddr];
        phys_rvld_reg <= valid_reg[raddr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == OP_EVICT_WR) begin
            swap_mem[SW_AW'({best_page_reg, k_reg})] <= rd_word;
        end
        swap_rd_reg <= swap_mem[SW_AW'({page_reg, k_reg})];
    end

    // a word not written since reset or since its frame was cleared reads as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (cmd.op == OP_GROW) begin
                for (int j = 0; j < PW; j++) begin
                    valid_reg[PA_W'({grow_frame, OFFSET_BITS'(j)})] <= 1'b0;
                end
            end
            if (cmd.op == OP_EVICT_FIN) begin
                for (int j = 0; j < PW; j++) begin
                    valid_reg[PA_W'({best_frame_reg, OFFSET_BITS'(j)})] <= 1'b0;
                end
            end
            if (we) begin
                valid_reg[waddr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            saved_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == OP_EVICT_FIN) begin
                saved_reg[best_page_reg] <= 1'b1;
            end
            if (cmd.op == OP_REST_FIN) begin
                saved_reg[page_reg] <= 1'b0;
            end
            if (cmd.op == OP_RESULT_OK || cmd.op == OP_RESULT_FAIL) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD: begin
                func_reg   <= s_tuser;
                va_reg     <= va_in;
                wd_reg     <= signed'(s_tdata[VA_W +: WDATA_W]);
                page_reg   <= (PAGE_BITS == 0) ? '0 : PG_W'(va_in >> OFFSET_BITS);
                cur_reg    <= '0;
                i_reg      <= '0;
                linked_reg <= 1'b0;
                k_reg      <= '0;
            end
            OP_WALK_ADV: begin
                cur_reg <= ent_frame;
                i_reg   <= i_reg + 1'b1;
            end
            OP_SCAN_INIT: begin
                d_reg             <= '0;
                frame_stk_reg[0]  <= '0;
                parent_stk_reg[0] <= '0;
                idx_stk_reg[0]    <= '0;
                kids_stk_reg[0]   <= 1'b0;
                vpage_stk_reg[0]  <= '0;
                max_reg           <= '0;
                victim_reg        <= 1'b0;
                best_dist_reg     <= '0;
                best_frame_reg    <= '0;
                best_page_reg     <= '0;
                best_parent_reg   <= '0;
                k_reg             <= '0;
            end
            OP_SCAN_CHK: begin
                if (status.ent_nz) begin
                    kids_stk_reg[d_reg] <= 1'b1;
                    if (ent_frame > max_reg) begin
                        max_reg <= ent_frame;
                    end
                    if (status.leaf) begin
                        // keep the first leaf on ties
                        if (cyc_gap > best_dist_reg) begin
                            best_dist_reg   <= cyc_gap;
                            best_frame_reg  <= ent_frame;
                            best_page_reg   <= vpage_next;
                            best_parent_reg <= {frame_cur, idx_cur};
                            victim_reg      <= 1'b1;
                        end
                    end else begin
                        frame_stk_reg[LVL_W'(d_reg + 1'b1)]  <= ent_frame;
                        parent_stk_reg[LVL_W'(d_reg + 1'b1)] <= {frame_cur, idx_cur};
                        idx_stk_reg[LVL_W'(d_reg + 1'b1)]    <= '0;
                        kids_stk_reg[LVL_W'(d_reg + 1'b1)]   <= 1'b0;
                        vpage_stk_reg[LVL_W'(d_reg + 1'b1)]  <= vpage_next;
                        d_reg                                <= d_reg + 1'b1;
                    end
                end
            end
            OP_SCAN_ADV: begin
                if (!status.idx_last) begin
                    idx_stk_reg[d_reg] <= idx_cur + 1'b1;
                end else if (!status.tbl_empty && !status.d_zero) begin
                    d_reg <= d_reg - 1'b1;
                end
            end
            OP_UNLINK:     nf_reg <= frame_cur;
            OP_GROW:       nf_reg <= grow_frame;
            OP_EVICT_WR:   k_reg  <= k_reg + 1'b1;
            OP_EVICT_FIN:  nf_reg <= best_frame_reg;
            OP_LINK: begin
                cur_reg    <= nf_reg;
                i_reg      <= i_reg + 1'b1;
                linked_reg <= status.walk_last;
            end
            OP_REST_WR:    k_reg <= k_reg + 1'b1;
            OP_RESULT_OK: begin
                out_data_reg <= func_reg ? '0 : RDATA_W'(rd_word);
                out_ok_reg   <= 1'b1;
            end
            OP_RESULT_FAIL: begin
                out_data_reg <= '0;
                out_ok_reg   <= 1'b0;
            end
            default: begin
            end
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_ok_reg;

endmodule

FILE: hw/rtl/ptwe_ctrl.sv
// Controller: sequences walk, frame scan, eviction, restore and access steps.
module ptwe_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  ptwe_pkg::dp_status_t  status,
    output ptwe_pkg::dp_cmd_t     cmd
);
    import ptwe_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        cmd.op       = OP_NONE;
        cmd.in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                cmd.in_ready = 1'b1;
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = status.in_oor ? ST_FAIL : ST_WALK_RD;
                end
            end
            ST_WALK_RD: begin
                cmd.op     = OP_WALK_RD;
                state_next = ST_WALK_CHK;
            end
            ST_WALK_CHK: begin
                if (status.ent_nz) begin
                    cmd.op     = OP_WALK_ADV;
                    state_next = status.walk_last ? ST_REST : ST_WALK_RD;
                end else begin
                    cmd.op     = OP_SCAN_INIT;
                    state_next = ST_SC_RD;
                end
            end
            ST_SC_RD: begin
                cmd.op     = OP_SCAN_RD;
                state_next = ST_SC_CHK;
            end
            ST_SC_CHK: begin
                cmd.op     = OP_SCAN_CHK;
                // descend into a linked table, otherwise step to the next entry
                state_next = (status.ent_nz && !status.leaf) ? ST_SC_RD : ST_SC_ADV;
            end
            ST_SC_ADV: begin
                cmd.op = OP_SCAN_ADV;
                priority if (!status.idx_last) begin
                    state_next = ST_SC_RD;
                end else if (status.tbl_empty) begin
                    state_next = ST_UNLINK;
                end else if (status.d_zero) begin
                    state_next = ST_TAKE;
                end else begin
                    state_next = ST_SC_ADV;
                end
            end
            ST_UNLINK: begin
                cmd.op     = OP_UNLINK;
                state_next = ST_LINK;
            end
            ST_TAKE: begin
                priority if (status.can_grow) begin
                    cmd.op     = OP_GROW;
                    state_next = ST_LINK;
                end else if (status.victim) begin
                    state_next = ST_EV_RD;
                end else begin
                    state_next = ST_FAIL;
                end
            end
            ST_EV_RD: begin
                cmd.op     = OP_EVICT_RD;
                state_next = ST_EV_WR;
            end
            ST_EV_WR: begin
                cmd.op     = OP_EVICT_WR;
                state_next = status.k_last ? ST_EV_FIN : ST_EV_RD;
            end
            ST_EV_FIN: begin
                cmd.op     = OP_EVICT_FIN;
                state_next = ST_LINK;
            end
            ST_LINK: begin
                cmd.op     = OP_LINK;
                state_next = status.walk_last ? ST_REST : ST_WALK_RD;
            end
            ST_REST: begin
                state_next = status.rest_need ? ST_RS_RD : ST_ACC;
            end
            ST_RS_RD: begin
                cmd.op     = OP_REST_RD;
                state_next = ST_RS_WR;
            end
            ST_RS_WR: begin
                cmd.op     = OP_REST_WR;
                state_next = status.k_last ? ST_RS_FIN : ST_RS_RD;
            end
            ST_RS_FIN: begin
                cmd.op     = OP_REST_FIN;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.op     = OP_ACC;
                state_next = ST_RESP;
            end
            ST_RESP: begin
                // hold until the result register frees up
                if (!status.out_busy) begin
                    cmd.op     = OP_RESULT_OK;
                    state_next = ST_IDLE;
                end
            end
            ST_FAIL: begin
                if (!status.out_busy) begin
                    cmd.op     = OP_RESULT_FAIL;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

FILE: tb/sv/page_table_walk_with_eviction_unit_test.sv
// Testbench for the page table walker: directed table, random accesses, reference prediction.
`timescale 1ns / 100ps

module page_table_walk_with_eviction_unit_test;
    import ptwe_pkg::*;

    localparam int PAGE_WORDS = 1 << PTWE_OFFSET_BITS;
    localparam int PAGE_COUNT = 1 << (PTWE_VADDR_BITS - PTWE_OFFSET_BITS);
    localparam int PHYS_WORDS = PTWE_FRAME_COUNT * PAGE_WORDS;
    localparam int RANDOM_ITEMS = 1750;
    localparam int STALL_LIMIT  = 20000;

    typedef enum logic {ACC_READ = 1'b0, ACC_WRITE = 1'b1} access_t;

    typedef struct packed {
        access_t     func;
        logic [11:0] vaddr;
        logic [31:0] wdata;
    } access_item_t;

    typedef struct packed {
        logic [31:0] rdata;
        logic        ok;
    } access_result_t;

    typedef struct packed {
        access_t     func;
        logic [11:0] vaddr;
        logic [31:0] wdata;
        logic        known;
        logic [31:0] rdata;
        logic        ok;
    } directed_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;

    page_table_walk_with_eviction_unit uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always #10 aclk = ~aclk;

    // shadow of the block's memory
    logic [31:0] phys_mem [PHYS_WORDS];
    logic [31:0] swap_mem [PAGE_COUNT * PAGE_WORDS];
    logic        page_saved [PAGE_COUNT];

    // frame search results
    bit          fs_empty, fs_victim;
    int unsigned fs_empty_frame, fs_empty_parent, fs_max_frame;
    int unsigned fs_best_dist, fs_best_frame, fs_best_page, fs_best_parent;
    int unsigned fs_exclude, fs_want;

    access_result_t expected_results[$];
    access_result_t typed_results[$];
    bit             typed_valid[$];
    int             error_count = 0;
    int             result_count = 0;
    int             fault_refusals = 0;
    int             idle_cycles = 0;
    bit             ignore_wd = 1'b0;

    function automatic logic [31:0] phys_rd(int unsigned a);
        return (a < PHYS_WORDS) ? phys_mem[a] : 32'd0;
    endfunction

    function automatic void phys_wr(int unsigned a, logic [31:0] v);
        if (a < PHYS_WORDS) phys_mem[a] = v;
    endfunction

    function automatic int unsigned page_distance(int unsigned a, int unsigned b);
        int unsigned d;
        d = (a > b) ? a - b : b - a;
        return (PAGE_COUNT - d < d) ? PAGE_COUNT - d : d;
    endfunction

    function automatic void search_tree(int unsigned vpage, int unsigned frame,
                                        int unsigned parent, int level);
        bit          kids;
        int unsigned v, pg, d;
        kids = 1'b0;
        if (fs_empty) return;
        if (level >= PTWE_LEVELS) begin
            pg = vpage % PAGE_COUNT;
            d = page_distance(fs_want, pg);
            if (d > fs_best_dist) begin
                fs_best_dist = d;
                fs_best_frame = frame;
                fs_best_page = pg;
                fs_best_parent = parent;
                fs_victim = 1'b1;
            end
            return;
        end
        for (int i = 0; i < PAGE_WORDS; i++) begin
            v = phys_rd(frame * PAGE_WORDS + i);
            if (v != 0) begin
                kids = 1'b1;
                if (v > fs_max_frame) fs_max_frame = v;
                search_tree(vpage * PAGE_WORDS + i, v, frame * PAGE_WORDS + i, level + 1);
                if (fs_empty) return;
            end
        end
        if (!kids && frame != fs_exclude) begin
            fs_empty = 1'b1;
            fs_empty_frame = frame;
            fs_empty_parent = parent;
        end
    endfunction

    function automatic bit claim_frame(int unsigned cur, int unsigned page,
                                       output int unsigned frame);
        fs_empty = 0; fs_empty_frame = 0; fs_empty_parent = 0; fs_max_frame = 0;
        fs_victim = 0; fs_best_dist = 0; fs_best_frame = 0; fs_best_page = 0;
        fs_best_parent = 0; fs_exclude = cur; fs_want = page;
        frame = 0;
        search_tree(0, 0, 0, 0);
        if (fs_empty) begin
            phys_wr(fs_empty_parent, 0);
            frame = fs_empty_frame;
            return 1'b1;
        end
        if (fs_max_frame + 1 < PTWE_FRAME_COUNT) begin
            for (int i = 0; i < PAGE_WORDS; i++) phys_wr((fs_max_frame + 1) * PAGE_WORDS + i, 0);
            frame = fs_max_frame + 1;
            return 1'b1;
        end
        if (!fs_victim) return 1'b0;
        // swap out the farthest page
        for (int i = 0; i < PAGE_WORDS; i++) begin
            swap_mem[fs_best_page * PAGE_WORDS + i] = phys_rd(fs_best_frame * PAGE_WORDS + i);
            phys_wr(fs_best_frame * PAGE_WORDS + i, 0);
        end
        page_saved[fs_best_page] = 1'b1;
        phys_wr(fs_best_parent, 0);
        frame = fs_best_frame;
        return 1'b1;
    endfunction

    function automatic access_result_t translate_access(access_item_t it);
        access_result_t r;
        int unsigned page, cur, idx, ent, nf;
        bit new_leaf;
        r = '0;
        cur = 0;
        new_leaf = 1'b0;
        page = (it.vaddr >> PTWE_OFFSET_BITS) % PAGE_COUNT;
        for (int lv = 0; lv < PTWE_LEVELS; lv++) begin
            idx = (it.vaddr >> ((PTWE_LEVELS - lv) * PTWE_OFFSET_BITS)) % PAGE_WORDS;
            ent = phys_rd(cur * PAGE_WORDS + idx);
            if (ent == 0) begin
                if (!claim_frame(cur, page, nf)) return r;
                phys_wr(cur * PAGE_WORDS + idx, nf);
                cur = nf;
                new_leaf = (lv + 1 == PTWE_LEVELS);
            end else begin
                cur = ent;
            end
        end
        if (new_leaf && page_saved[page]) begin
            for (int i = 0; i < PAGE_WORDS; i++)
                phys_wr(cur * PAGE_WORDS + i, swap_mem[page * PAGE_WORDS + i]);
            page_saved[page] = 1'b0;
        end
        if (it.func == ACC_WRITE)
            phys_wr(cur * PAGE_WORDS + it.vaddr[3:0], it.wdata);
        else
            r.rdata = phys_rd(cur * PAGE_WORDS + it.vaddr[3:0]);
        r.ok = 1'b1;
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    function automatic int unsigned gap_cycles();
        int unsigned p;
        if (ignore_wd) return 0;
        p = $urandom_range(99);
        if (p < 60) return 0;
        if (p < 95) return $urandom_range(3, 1);
        return $urandom_range(60, 15);
    endfunction

    // input side: record and predict each accepted transaction
    always @(posedge aclk) begin
        access_item_t it;
        access_result_t want;
        access_result_t typed;
        bit known;
        if (aresetn && s_tvalid && s_tready) begin
            it.func = access_t'(s_tuser);
            it.vaddr = s_tdata[11:0];
            it.wdata = s_tdata[43:12];
            want = translate_access(it);
            if (typed_valid.size() != 0) begin
                known = typed_valid.pop_front();
                typed = typed_results.pop_front();
                if (known) begin
                    if (want != typed) begin
                        $display("[%0t] directed row disagrees with prediction", $time);
                        error_count++;
                    end
                    want = typed;
                end
            end
            expected_results.push_back(want);
        end
    end

    // output side: compare against the oldest expectation
    always @(posedge aclk) begin
        access_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            result_count++;
            if (expected_results.size() == 0) begin
                $display("[%0t] result with nothing expected", $time);
                error_count++;
            end else begin
                want = expected_results.pop_front();
                if (m_tdata !== want.rdata) report_mismatch("read_data", m_tdata, want.rdata);
                if (m_tuser !== want.ok) report_mismatch("ok", m_tuser, want.ok);
                if (!want.ok) fault_refusals++;
            end
        end
    end

    // receiver stalls
    always @(posedge aclk) begin
        if (!aresetn) m_tready <= 1'b0;
        else m_tready <= ignore_wd ? 1'b1 : (gap_cycles() == 0);
    end

    // watchdog on accepted transactions
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic send_access(access_item_t it);
        int unsigned g;
        g = gap_cycles();
        // hold valid low after the previous transaction for a gap drawn from gap_cycles
        repeat (g + 1) @(posedge aclk);
        s_tvalid <= 1'b1;
        s_tuser  <= it.func;
        s_tdata  <= {4'd0, it.wdata, it.vaddr};
        do @(posedge aclk); while (!s_tready);
        s_tvalid <= 1'b0;
    endtask

    directed_row_t directed_rows[] = '{
        '{ACC_READ,  12'h000, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b1},
        '{ACC_READ,  12'hFFF, 32'h0,         1'b1, 32'h0, 1'b1},
        '{ACC_WRITE, 12'hFFF, 32'h7FFF_FFFF, 1'b1, 32'h0, 1'b1},
        '{ACC_READ,  12'hFFF, 32'h0,         1'b1, 32'h7FFF_FFFF, 1'b1},
        '{ACC_WRITE, 12'h000, 32'h8000_0000, 1'b1, 32'h0, 1'b1},
        '{ACC_READ,  12'h000, 32'h0,         1'b1, 32'h8000_0000, 1'b1},
        '{ACC_WRITE, 12'h00F, 32'hFFFF_FFFF, 1'b1, 32'h0, 1'b1},
        '{ACC_READ,  12'h00F, 32'h0,         1'b1, 32'hFFFF_FFFF, 1'b1},
        '{ACC_WRITE, 12'h810, 32'h1234_5678, 1'b0, 32'h0, 1'b0},
        '{ACC_WRITE, 12'h120, 32'hA5A5_5A5A, 1'b0, 32'h0, 1'b0},
        '{ACC_WRITE, 12'h230, 32'h0000_0001, 1'b0, 32'h0, 1'b0},
        '{ACC_WRITE, 12'h340, 32'h0000_0002, 1'b0, 32'h0, 1'b0},
        '{ACC_WRITE, 12'h450, 32'h0000_0003, 1'b0, 32'h0, 1'b0},
        '{ACC_WRITE, 12'h560, 32'h0000_0004, 1'b0, 32'h0, 1'b0},
        // by now frames run out: evict to swap, then bring pages back
        '{ACC_WRITE, 12'h670, 32'h0000_0005, 1'b0, 32'h0, 1'b0},
        '{ACC_WRITE, 12'h780, 32'h0000_0006, 1'b0, 32'h0, 1'b0},
        '{ACC_WRITE, 12'h890, 32'h0000_0007, 1'b0, 32'h0, 1'b0},
        '{ACC_WRITE, 12'h9A0, 32'h0000_0008, 1'b0, 32'h0, 1'b0},
        '{ACC_READ,  12'hFFF, 32'h0,         1'b0, 32'h0, 1'b0},
        '{ACC_READ,  12'h000, 32'h0,         1'b0, 32'h0, 1'b0},
        '{ACC_READ,  12'h810, 32'h0,         1'b0, 32'h0, 1'b0},
        '{ACC_READ,  12'h120, 32'h0,         1'b0, 32'h0, 1'b0}
    };

    initial begin
        access_item_t it;
        int unsigned hot_pages[8];
        for (int i = 0; i < PHYS_WORDS; i++) phys_mem[i] = '0;
        for (int i = 0; i < PAGE_COUNT; i++) page_saved[i] = 1'b0;
        for (int i = 0; i < PAGE_COUNT * PAGE_WORDS; i++) swap_mem[i] = '0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            typed_valid.push_back(directed_rows[i].known);
            typed_results.push_back({directed_rows[i].rdata, directed_rows[i].ok});
            send_access({directed_rows[i].func, directed_rows[i].vaddr, directed_rows[i].wdata});
        end
        // let the block drain before the random part
        do @(posedge aclk); while (expected_results.size() != 0);

        foreach (hot_pages[i]) hot_pages[i] = $urandom_range(PAGE_COUNT - 1);
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            ignore_wd = (n % 400) >= 340;  // stretch with no stalls
            if (n % 150 == 0) hot_pages[$urandom_range(7)] = $urandom_range(PAGE_COUNT - 1);
            it.func = access_t'($urandom_range(1));
            if ($urandom_range(99) < 75)
                it.vaddr = {hot_pages[$urandom_range(7)][7:0], 4'($urandom_range(15))};
            else
                it.vaddr = 12'($urandom);
            case ($urandom_range(7))
                0: it.wdata = 32'h8000_0000;
                1: it.wdata = 32'h7FFF_FFFF;
                2: it.wdata = 32'hFFFF_FFFF;
                default: it.wdata = $urandom;
            endcase
            send_access(it);
        end
        ignore_wd = 1'b0;

        do @(posedge aclk); while (expected_results.size() != 0);
        repeat (100) @(posedge aclk);
        $display("Covered %0d directed and %0d random accesses, %0d results, %0d refused.",
                 directed_rows.size(), RANDOM_ITEMS, result_count, fault_refusals);
        if (error_count == 0) $display("Simulation PASSED");
        else $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
hw/rtl/ptwe_pkg.sv
hw/rtl/ptwe_dp.sv
hw/rtl/ptwe_ctrl.sv
hw/rtl/page_table_walk_with_eviction_unit.sv
tb/sv/page_table_walk_with_eviction_unit_test.sv
